@@ hw/rtl/round_robin_schedule_sim_core_defines.svh @@
// Assertion macros for the round-robin scheduler RTL.
`ifndef ROUND_ROBIN_SCHEDULE_SIM_CORE_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULE_SIM_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define RRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rrs_pkg.sv @@
// Shared types and constants of the round-robin scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  localparam int unsigned NPROC_DEF = 32;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned PIDX_W    = 6;

  localparam logic [DATA_W-1:0] QUANTUM_RST = 16'd4;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_CMP,
    ST_ADV,
    ST_OUT_RD,
    ST_OUT_TAT,
    ST_OUT_WT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rrs_alu.sv @@
// Shared 24-bit add/subtract unit with carry out for compares.
`timescale 1ns / 1ps
`default_nettype none

module rrs_alu (
  input  rrs_pkg::alu_req_t req,
  output rrs_pkg::alu_rsp_t rsp
);

  logic [rrs_pkg::TIME_W-1:0] b_op;
  logic [rrs_pkg::TIME_W:0]   total;

  // Subtract as a + ~b + 1; carry set means no borrow (a >= b).
  assign b_op  = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_op} + {{rrs_pkg::TIME_W{1'b0}}, req.sub};

  assign rsp.sum   = total[rrs_pkg::TIME_W-1:0];
  assign rsp.carry = total[rrs_pkg::TIME_W];

endmodule

`default_nettype wire

@@ hw/rtl/rrs_seq.sv @@
// Scheduling sequencer: process tables, ready ring and run/report control.
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_schedule_sim_core_defines.svh"

module rrs_seq #(
  parameter int unsigned NPROC = rrs_pkg::NPROC_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_action,
  input  wire logic [rrs_pkg::DATA_W-1:0]  in_arrival_time,
  input  wire logic [rrs_pkg::DATA_W-1:0]  in_burst_time,
  input  wire logic [rrs_pkg::DATA_W-1:0]  quantum,
  input  wire logic                        out_free,
  output logic                             res_push,
  output rrs_pkg::result_t                 res,
  output rrs_pkg::alu_req_t                alu_req,
  input  rrs_pkg::alu_rsp_t                alu_rsp
);

  localparam int unsigned IW = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int unsigned CW = $clog2(NPROC + 1);
  localparam int unsigned DW = rrs_pkg::DATA_W;
  localparam int unsigned TW = rrs_pkg::TIME_W;
  localparam int unsigned PW = TW - DW;

  // Tables and ready ring
  logic [DW-1:0] arr_mem  [NPROC];
  logic [DW-1:0] burst_mem[NPROC];
  logic [DW-1:0] rem_mem  [NPROC];
  logic [TW-1:0] comp_mem [NPROC];
  logic [IW-1:0] ring_mem [NPROC];

  logic [DW-1:0] arr_rd_r, burst_rd_r, rem_rd_r;
  logic [TW-1:0] comp_rd_r;
  logic [IW-1:0] ring_rd_r;

  rrs_pkg::state_t state_r, state_nxt;

  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [IW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    loaded_r, loaded_nxt;
  logic [CW-1:0]    done_r, done_nxt;
  logic [TW-1:0]    time_r, time_nxt;
  logic [DW-1:0]    min_r, min_nxt;
  logic             minv_r, minv_nxt;
  logic             pend_r, pend_nxt;
  logic             gt_r, gt_nxt;
  logic [DW-1:0]    diff_r, diff_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [TW-1:0]    tat_r, tat_nxt;
  logic [NPROC-1:0] queued_r, queued_nxt;

  logic          load_we;
  logic          rem_we;
  logic [IW-1:0] rem_wa;
  logic [DW-1:0] rem_wd;
  logic          comp_we;
  logic          ring_we;
  logic [IW-1:0] ring_wd;

  logic          in_acc;
  logic          idx_last;
  logic          full;
  logic          scan_push;
  logic          run_go;
  logic [CW:0]   tail_sum;
  logic [IW-1:0] tail_idx;
  logic [IW-1:0] head_inc;
  logic          in_run;
  logic          run_beat;
  logic          idle_gap;

  assign in_acc    = in_valid && !in_stall;
  assign idx_last  = (CW'(idx_r) + CW'(1)) == loaded_r;
  assign full      = loaded_r == CW'(NPROC);
  assign scan_push = !queued_r[idx_r] && alu_rsp.carry;
  assign run_go    = in_valid && (in_action == rrs_pkg::ACT_RUN) && (loaded_r != '0);

  assign in_run   = state_r != rrs_pkg::ST_IDLE;
  assign run_beat = (state_r == rrs_pkg::ST_IDLE) && run_go;
  assign idle_gap = (state_r == rrs_pkg::ST_SCAN_END) && (count_r == '0) && !pend_r
                    && (done_r != loaded_r);

  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign tail_idx = (tail_sum >= (CW+1)'(NPROC)) ? IW'(tail_sum - (CW+1)'(NPROC))
                                                 : IW'(tail_sum);
  assign head_inc = (head_r == IW'(NPROC - 1)) ? '0 : head_r + IW'(1);

  always_ff @(posedge clk) begin
    if (load_we) begin
      arr_mem[loaded_r[IW-1:0]]   <= in_arrival_time;
      burst_mem[loaded_r[IW-1:0]] <= in_burst_time;
    end
    arr_rd_r   <= arr_mem[idx_r];
    burst_rd_r <= burst_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rem_rd_r <= rem_mem[ring_rd_r];
  end

  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[cur_r] <= alu_rsp.sum;
    end
    comp_rd_r <= comp_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[tail_idx] <= ring_wd;
    end
    ring_rd_r <= ring_mem[head_r];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrs_pkg::ST_IDLE: begin
        if (run_go) begin
          state_nxt = rrs_pkg::ST_INIT_RD;
        end
      end
      rrs_pkg::ST_INIT_RD:  state_nxt = rrs_pkg::ST_INIT_WR;
      rrs_pkg::ST_INIT_WR:  state_nxt = idx_last ? rrs_pkg::ST_SCAN_RD : rrs_pkg::ST_INIT_RD;
      rrs_pkg::ST_SCAN_RD:  state_nxt = rrs_pkg::ST_SCAN_CHK;
      rrs_pkg::ST_SCAN_CHK: state_nxt = idx_last ? rrs_pkg::ST_SCAN_END : rrs_pkg::ST_SCAN_RD;
      rrs_pkg::ST_SCAN_END: begin
        if (done_r == loaded_r) begin
          state_nxt = rrs_pkg::ST_OUT_RD;
        end else if (count_r == '0 && !pend_r) begin
          state_nxt = rrs_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = rrs_pkg::ST_POP_RD;
        end
      end
      rrs_pkg::ST_POP_RD:   state_nxt = rrs_pkg::ST_POP_WAIT;
      rrs_pkg::ST_POP_WAIT: state_nxt = rrs_pkg::ST_CMP;
      rrs_pkg::ST_CMP:      state_nxt = rrs_pkg::ST_ADV;
      rrs_pkg::ST_ADV:      state_nxt = rrs_pkg::ST_SCAN_RD;
      rrs_pkg::ST_OUT_RD:   state_nxt = rrs_pkg::ST_OUT_TAT;
      rrs_pkg::ST_OUT_TAT:  state_nxt = rrs_pkg::ST_OUT_WT;
      rrs_pkg::ST_OUT_WT: begin
        if (out_free) begin
          state_nxt = idx_last ? rrs_pkg::ST_IDLE : rrs_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = rrs_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, shared unit operands and table writes
  always_comb begin
    in_stall = 1'b1;
    res_push = 1'b0;
    alu_req  = '0;
    load_we  = 1'b0;
    rem_we   = 1'b0;
    rem_wa   = idx_r;
    rem_wd   = burst_rd_r;
    comp_we  = 1'b0;
    ring_we  = 1'b0;
    ring_wd  = idx_r;
    case (state_r)
      rrs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        load_we  = in_valid && (in_action == rrs_pkg::ACT_LOAD) && !full;
      end
      rrs_pkg::ST_INIT_WR: begin
        rem_we = 1'b1;
      end
      rrs_pkg::ST_SCAN_CHK: begin
        alu_req = '{a: time_r, b: {{PW{1'b0}}, arr_rd_r}, sub: 1'b1};
        ring_we = scan_push;
      end
      rrs_pkg::ST_SCAN_END: begin
        ring_we = pend_r;
        ring_wd = cur_r;
      end
      rrs_pkg::ST_CMP: begin
        alu_req = '{a: {{PW{1'b0}}, rem_rd_r}, b: {{PW{1'b0}}, quantum}, sub: 1'b1};
      end
      rrs_pkg::ST_ADV: begin
        alu_req = '{a: time_r, b: {{PW{1'b0}}, (gt_r ? quantum : rem_r)}, sub: 1'b0};
        rem_we  = 1'b1;
        rem_wa  = cur_r;
        rem_wd  = gt_r ? diff_r : '0;
        comp_we = !gt_r;
      end
      rrs_pkg::ST_OUT_TAT: begin
        alu_req = '{a: comp_rd_r, b: {{PW{1'b0}}, arr_rd_r}, sub: 1'b1};
      end
      rrs_pkg::ST_OUT_WT: begin
        alu_req  = '{a: tat_r, b: {{PW{1'b0}}, burst_rd_r}, sub: 1'b1};
        res_push = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign res.process_index   = rrs_pkg::PIDX_W'(idx_r);
  assign res.completion_time = comp_rd_r;
  assign res.turnaround_time = tat_r;
  assign res.waiting_time    = alu_rsp.sum;
  assign res.last            = idx_last;

  // Datapath registers
  always_comb begin
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    loaded_nxt = loaded_r;
    done_nxt   = done_r;
    time_nxt   = time_r;
    min_nxt    = min_r;
    minv_nxt   = minv_r;
    pend_nxt   = pend_r;
    gt_nxt     = gt_r;
    diff_nxt   = diff_r;
    rem_nxt    = rem_r;
    tat_nxt    = tat_r;
    queued_nxt = queued_r;
    case (state_r)
      rrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_action)
            rrs_pkg::ACT_LOAD: begin
              if (!full) begin
                loaded_nxt = loaded_r + CW'(1);
              end
            end
            rrs_pkg::ACT_CLEAR: loaded_nxt = '0;
            rrs_pkg::ACT_RUN: begin
              if (loaded_r != '0) begin
                idx_nxt    = '0;
                queued_nxt = '0;
                head_nxt   = '0;
                count_nxt  = '0;
                done_nxt   = '0;
                time_nxt   = '0;
                pend_nxt   = 1'b0;
              end
            end
            default: loaded_nxt = loaded_r;
          endcase
        end
      end
      rrs_pkg::ST_INIT_WR: begin
        idx_nxt  = idx_last ? '0 : idx_r + IW'(1);
        minv_nxt = 1'b0;
      end
      rrs_pkg::ST_SCAN_CHK: begin
        if (scan_push) begin
          queued_nxt[idx_r] = 1'b1;
          count_nxt         = count_r + CW'(1);
        end else if (!queued_r[idx_r] && (!minv_r || arr_rd_r < min_r)) begin
          // track the earliest arrival still to come, for idle skips
          min_nxt  = arr_rd_r;
          minv_nxt = 1'b1;
        end
        idx_nxt = idx_last ? '0 : idx_r + IW'(1);
      end
      rrs_pkg::ST_SCAN_END: begin
        if (pend_r) begin
          count_nxt = count_r + CW'(1);
          pend_nxt  = 1'b0;
        end else if (count_r == '0 && done_r != loaded_r) begin
          // processor idle: jump straight to the next arrival
          time_nxt = {{PW{1'b0}}, min_r};
          minv_nxt = 1'b0;
        end
      end
      rrs_pkg::ST_POP_RD: begin
        head_nxt  = head_inc;
        count_nxt = count_r - CW'(1);
      end
      rrs_pkg::ST_POP_WAIT: begin
        cur_nxt = ring_rd_r;
      end
      rrs_pkg::ST_CMP: begin
        gt_nxt   = alu_rsp.carry && (alu_rsp.sum[DW-1:0] != '0);
        diff_nxt = alu_rsp.sum[DW-1:0];
        rem_nxt  = rem_rd_r;
      end
      rrs_pkg::ST_ADV: begin
        time_nxt = alu_rsp.sum;
        if (!gt_r) begin
          done_nxt = done_r + CW'(1);
        end
        pend_nxt = gt_r;
        idx_nxt  = '0;
        minv_nxt = 1'b0;
      end
      rrs_pkg::ST_OUT_TAT: begin
        tat_nxt = alu_rsp.sum;
      end
      rrs_pkg::ST_OUT_WT: begin
        if (out_free && !idx_last) begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rrs_pkg::ST_IDLE;
      idx_r    <= '0;
      head_r   <= '0;
      count_r  <= '0;
      loaded_r <= '0;
      done_r   <= '0;
      time_r   <= '0;
      minv_r   <= 1'b0;
      pend_r   <= 1'b0;
      queued_r <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      loaded_r <= loaded_nxt;
      done_r   <= done_nxt;
      time_r   <= time_nxt;
      minv_r   <= minv_nxt;
      pend_r   <= pend_nxt;
      queued_r <= queued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    min_r  <= min_nxt;
    gt_r   <= gt_nxt;
    diff_r <= diff_nxt;
    rem_r  <= rem_nxt;
    tat_r  <= tat_nxt;
  end

  `RRS_ASSERT_ALWAYS(a_ring_bound, count_r <= CW'(NPROC), "ready ring over capacity")
  `RRS_ASSERT_IMPL(a_done_bound, in_run, done_r <= loaded_r, "more completions than processes")
  `RRS_ASSERT_IMPL(a_push_free, res_push, out_free, "result pushed into a full register")
  `RRS_ASSERT_NEXT(a_run_start, run_beat, state_r == rrs_pkg::ST_INIT_RD, "run beat not started")
  `RRS_ASSERT_IMPL(a_idle_jump, idle_gap, minv_r, "idle with no pending arrival")

endmodule

`default_nettype wire

@@ hw/rtl/round_robin_schedule_sim_core.sv @@
// Top level of the round-robin scheduling simulator.
//
//  Channel | Signals                                          | Direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, in_action, in_arrival_time,   | in
//          | in_burst_time                                    |
//  out     | out_valid, out_stall, out_process_index,          | out
//          | out_completion_time, out_turnaround_time,         |
//          | out_waiting_time, out_last                        |
//  cfg     | cfg_we, cfg_wdata (time quantum)                  | in
//
// Load, clear and unused actions complete while idle. A run reloads the L remaining times
// from the burst times and scans the arrivals, then per dispatch pops, compares, advances
// and scans again; an idle gap costs one scan and jumps to the arrival. Each result then
// passes through the shared add/subtract unit, and output stalls hold it back.
// Reset (synchronous, rst_n low) empties the table and sets the quantum to 4.
// The block stalls its input for the whole run; one result register decouples out_stall.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_schedule_sim_core #(
  parameter int unsigned NPROC = rrs_pkg::NPROC_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [rrs_pkg::DATA_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_action,
  input  wire logic [rrs_pkg::DATA_W-1:0]  in_arrival_time,
  input  wire logic [rrs_pkg::DATA_W-1:0]  in_burst_time,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rrs_pkg::PIDX_W-1:0]       out_process_index,
  output logic [rrs_pkg::TIME_W-1:0]       out_completion_time,
  output logic [rrs_pkg::TIME_W-1:0]       out_turnaround_time,
  output logic [rrs_pkg::TIME_W-1:0]       out_waiting_time,
  output logic                             out_last
);

  logic [rrs_pkg::DATA_W-1:0] quantum_r, quantum_nxt;
  logic [rrs_pkg::DATA_W-1:0] quantum_eff;
  logic                       out_valid_r, out_valid_nxt;
  rrs_pkg::result_t           res_r;
  rrs_pkg::result_t           res;
  logic                       res_push;
  logic                       out_free;
  rrs_pkg::alu_req_t          alu_req;
  rrs_pkg::alu_rsp_t          alu_rsp;

  assign quantum_nxt = cfg_we ? cfg_wdata : quantum_r;
  // a zero quantum behaves as one
  assign quantum_eff = (quantum_r == '0) ? rrs_pkg::DATA_W'(1) : quantum_r;

  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = res_push || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= rrs_pkg::QUANTUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      quantum_r   <= quantum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the beat until it is taken
  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r <= res;
    end
  end

  rrs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  rrs_seq #(
    .NPROC (NPROC)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_arrival_time (in_arrival_time),
    .in_burst_time   (in_burst_time),
    .quantum         (quantum_eff),
    .out_free        (out_free),
    .res_push        (res_push),
    .res             (res),
    .alu_req         (alu_req),
    .alu_rsp         (alu_rsp)
  );

  assign out_valid           = out_valid_r;
  assign out_process_index   = res_r.process_index;
  assign out_completion_time = res_r.completion_time;
  assign out_turnaround_time = res_r.turnaround_time;
  assign out_waiting_time    = res_r.waiting_time;
  assign out_last            = res_r.last;

endmodule

`default_nettype wire
